@@ hw/rtl/i2cbm_pkg.sv @@
// Types and constants shared by the I2C bit-level master.
package i2cbm_pkg;

    localparam logic [2:0] MODE_START   = 3'd0;
    localparam logic [2:0] MODE_STOP    = 3'd1;
    localparam logic [2:0] MODE_TX_BYTE = 3'd2;
    localparam logic [2:0] MODE_RX_BYTE = 3'd3;
    localparam logic [2:0] MODE_TX_ACK  = 3'd4;
    localparam logic [2:0] MODE_RX_ACK  = 3'd5;

    localparam logic [7:0] MSB_MASK      = 8'h80;
    localparam logic [1:0] PHASE_LAST    = 2'd2;
    localparam logic       HOLD_ADDR_SEL = 1'b0;
    localparam logic [7:0] HOLD_RESET    = 8'd1;

    typedef enum logic [6:0] {
        CMD_IDLE    = 7'b0000001,
        CMD_START   = 7'b0000010,
        CMD_STOP    = 7'b0000100,
        CMD_TX_BYTE = 7'b0001000,
        CMD_RX_BYTE = 7'b0010000,
        CMD_TX_ACK  = 7'b0100000,
        CMD_RX_ACK  = 7'b1000000
    } cmd_t;

    typedef enum logic [2:0] {
        ACT_SCL0 = 3'd0,
        ACT_SCL1 = 3'd1,
        ACT_SDA0 = 3'd2,
        ACT_SDA1 = 3'd3,
        ACT_READ = 3'd4
    } act_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] tx_byte;
        logic       ack_out;
        logic       sda_in;
    } in_item_t;

    typedef struct packed {
        logic       scl_line;
        logic       sda_line;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_in;
        logic       rejected;
    } out_item_t;

    function automatic logic [4:0] cmd_length(input cmd_t cmd);
        case (cmd)
            CMD_START:   cmd_length = 5'd4;
            CMD_STOP:    cmd_length = 5'd3;
            CMD_TX_BYTE: cmd_length = 5'd24;
            CMD_RX_BYTE: cmd_length = 5'd25;
            CMD_TX_ACK:  cmd_length = 5'd3;
            CMD_RX_ACK:  cmd_length = 5'd4;
            default:     cmd_length = 5'd0;
        endcase
    endfunction

    function automatic cmd_t mode_to_cmd(input logic [2:0] mode);
        case (mode)
            MODE_START:   mode_to_cmd = CMD_START;
            MODE_STOP:    mode_to_cmd = CMD_STOP;
            MODE_TX_BYTE: mode_to_cmd = CMD_TX_BYTE;
            MODE_RX_BYTE: mode_to_cmd = CMD_RX_BYTE;
            MODE_TX_ACK:  mode_to_cmd = CMD_TX_ACK;
            MODE_RX_ACK:  mode_to_cmd = CMD_RX_ACK;
            default:      mode_to_cmd = CMD_IDLE;
        endcase
    endfunction

endpackage

@@ hw/rtl/i2c_bit_level_master.sv @@
// Latency: the result beat for an input beat is registered at the edge that accepts it.
// Throughput: one input beat per cycle when not stalled; one status update per input beat.
// A pin action advances on at most one tick beat; a command spans its steps times hold_ticks.
// The output register frees on the same edge it is taken, so input stalls only on m_ready low.
// Reset (aresetn low, synchronous): both lines released high, sequencer idle, hold_ticks 1.
module i2c_bit_level_master (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  i2cbm_pkg::in_item_t   s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output i2cbm_pkg::out_item_t  m_item,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import i2cbm_pkg::*;

    logic [7:0] hold_reg;
    logic       scl_reg, scl_next;
    logic       sda_reg, sda_next;
    cmd_t       cmd_reg, cmd_next, cmd_eff;
    logic [4:0] step_reg, step_next, step_eff;
    logic [7:0] tick_reg, tick_next;
    logic [7:0] shreg_reg, shreg_next, shreg_eff;
    logic       ack_reg, ack_next;
    logic [7:0] latch_reg, latch_next, latch_eff;
    logic [1:0] phase_reg, phase_next, phase_eff;
    logic [2:0] bit_reg, bit_next, bit_eff;
    logic       m_valid_reg;
    out_item_t  m_item_reg, m_item_next;

    logic       accept;
    logic       do_step;
    logic       done;
    logic       rej;
    logic [8:0] tick_inc;
    logic [7:0] hold_eff;
    logic [7:0] bit_mask;
    act_t       act;

    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == HOLD_ADDR_SEL) ? {24'd0, hold_reg} : 32'd0;
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    always_comb begin
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        cmd_next   = cmd_reg;
        step_next  = step_reg;
        tick_next  = tick_reg;
        shreg_next = shreg_reg;
        ack_next   = ack_reg;
        latch_next = latch_reg;
        phase_next = phase_reg;
        bit_next   = bit_reg;
        cmd_eff    = cmd_reg;
        step_eff   = step_reg;
        shreg_eff  = shreg_reg;
        latch_eff  = latch_reg;
        phase_eff  = phase_reg;
        bit_eff    = bit_reg;
        do_step    = 1'b0;
        done       = 1'b0;
        rej        = 1'b0;
        tick_inc   = {1'b0, tick_reg} + 9'd1;
        hold_eff   = (hold_reg == 8'd0) ? 8'd1 : hold_reg;

        if (s_item.mode <= MODE_RX_ACK) begin
            if (cmd_reg != CMD_IDLE) begin
                rej = 1'b1;
            end else begin
                cmd_eff   = mode_to_cmd(s_item.mode);
                step_eff  = 5'd0;
                phase_eff = 2'd0;
                bit_eff   = 3'd0;
                if (s_item.mode == MODE_TX_BYTE) begin
                    latch_eff = s_item.tx_byte;
                end else if (s_item.mode == MODE_TX_ACK) begin
                    latch_eff = {7'd0, s_item.ack_out};
                end else begin
                    latch_eff = 8'd0;
                end
                if (s_item.mode == MODE_RX_BYTE) begin
                    shreg_eff = 8'd0;
                end
                do_step = 1'b1;
            end
        end else if (cmd_reg != CMD_IDLE) begin
            if (tick_inc >= {1'b0, hold_eff}) begin
                if (step_reg >= cmd_length(cmd_reg)) begin
                    cmd_next  = CMD_IDLE;
                    step_next = 5'd0;
                    tick_next = 8'd0;
                    done      = 1'b1;
                end else begin
                    do_step = 1'b1;
                end
            end else begin
                tick_next = tick_inc[7:0];
            end
        end

        bit_mask = MSB_MASK >> bit_eff;

        case (cmd_eff)
            CMD_START: begin
                case (step_eff[1:0])
                    2'd0:    act = ACT_SDA1;
                    2'd1:    act = ACT_SCL1;
                    2'd2:    act = ACT_SDA0;
                    default: act = ACT_SCL0;
                endcase
            end
            CMD_STOP: begin
                case (step_eff)
                    5'd0:    act = ACT_SDA0;
                    5'd1:    act = ACT_SCL1;
                    default: act = ACT_SDA1;
                endcase
            end
            CMD_TX_BYTE: begin
                case (phase_eff)
                    2'd0:    act = ((latch_eff & bit_mask) != 8'd0) ? ACT_SDA1 : ACT_SDA0;
                    2'd1:    act = ACT_SCL1;
                    default: act = ACT_SCL0;
                endcase
            end
            CMD_RX_BYTE: begin
                if (step_eff == 5'd0) begin
                    act = ACT_SDA1;
                end else begin
                    case (phase_eff)
                        2'd0:    act = ACT_SCL1;
                        2'd1:    act = ACT_READ;
                        default: act = ACT_SCL0;
                    endcase
                end
            end
            CMD_TX_ACK: begin
                case (step_eff)
                    5'd0:    act = latch_eff[0] ? ACT_SDA1 : ACT_SDA0;
                    5'd1:    act = ACT_SCL1;
                    default: act = ACT_SCL0;
                endcase
            end
            CMD_RX_ACK: begin
                case (step_eff[1:0])
                    2'd0:    act = ACT_SDA1;
                    2'd1:    act = ACT_SCL1;
                    2'd2:    act = ACT_READ;
                    default: act = ACT_SCL0;
                endcase
            end
            default: act = ACT_SDA1;
        endcase

        if (do_step) begin
            cmd_next   = cmd_eff;
            latch_next = latch_eff;
            shreg_next = shreg_eff;
            step_next  = step_eff + 5'd1;
            tick_next  = 8'd0;
            phase_next = phase_eff;
            bit_next   = bit_eff;
            case (act)
                ACT_SCL0: scl_next = 1'b0;
                ACT_SCL1: scl_next = 1'b1;
                ACT_SDA0: sda_next = 1'b0;
                ACT_SDA1: sda_next = 1'b1;
                default: begin
                    if (cmd_eff == CMD_RX_BYTE) begin
                        if (s_item.sda_in) begin
                            shreg_next = shreg_eff | bit_mask;
                        end
                    end else begin
                        ack_next = s_item.sda_in;
                    end
                end
            endcase
            if (!(cmd_eff == CMD_RX_BYTE && step_eff == 5'd0)) begin
                if (phase_eff == PHASE_LAST) begin
                    phase_next = 2'd0;
                    bit_next   = bit_eff + 3'd1;
                end else begin
                    phase_next = phase_eff + 2'd1;
                end
            end
        end

        m_item_next.scl_line = scl_next;
        m_item_next.sda_line = sda_next;
        m_item_next.busy_res = (cmd_next != CMD_IDLE);
        m_item_next.done_res = done;
        m_item_next.rx_byte  = shreg_next;
        m_item_next.ack_in   = ack_next;
        m_item_next.rejected = rej;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg    <= HOLD_RESET;
            scl_reg     <= 1'b1;
            sda_reg     <= 1'b1;
            cmd_reg     <= CMD_IDLE;
            step_reg    <= 5'd0;
            tick_reg    <= 8'd0;
            shreg_reg   <= 8'd0;
            ack_reg     <= 1'b0;
            latch_reg   <= 8'd0;
            phase_reg   <= 2'd0;
            bit_reg     <= 3'd0;
            m_valid_reg <= 1'b0;
        end else begin
            if (psel && penable && pwrite && paddr[2] == HOLD_ADDR_SEL) begin
                hold_reg <= pwdata[7:0];
            end
            if (accept) begin
                scl_reg     <= scl_next;
                sda_reg     <= sda_next;
                cmd_reg     <= cmd_next;
                step_reg    <= step_next;
                tick_reg    <= tick_next;
                shreg_reg   <= shreg_next;
                ack_reg     <= ack_next;
                latch_reg   <= latch_next;
                phase_reg   <= phase_next;
                bit_reg     <= bit_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_item_reg <= m_item_next;
        end
    end

endmodule
